### design/button_stepped_fast_pwm_core_macros.svh
// ----------------------------------------------------------------------------
// Button-stepped fast PWM core - assertion macros
// Shared concurrent assertion forms for the core's checks.
// ----------------------------------------------------------------------------
`ifndef BUTTON_STEPPED_FAST_PWM_CORE_MACROS_SVH
`define BUTTON_STEPPED_FAST_PWM_CORE_MACROS_SVH

// Check a consequent in the same cycle as its antecedent
`define BSPWM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequent in the cycle after its antecedent
`define BSPWM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/bspwm_pkg.sv
// ----------------------------------------------------------------------------
// bspwm_pkg
// Types, register map and constants of the button-stepped fast PWM core.
// ----------------------------------------------------------------------------
package bspwm_pkg;

   // Counter and register widths
   localparam int CounterBits  = 16;
   localparam int TopBits      = 16;
   localparam int PrescaleBits = 11;
   localparam int PrescaleCntBits = 10;
   localparam int DebounceBits = 24;
   localparam int DutyBits     = 7;
   localparam int StepBits     = 4;
   localparam int AddrBits     = 4;
   localparam int DataBits     = 32;

   // Duty is kept as a step index 0..10, one step being ten percent
   localparam int MaxStep = 10;
   localparam logic [StepBits-1:0] StepLimit = StepBits'(MaxStep - 1);
   localparam logic [DutyBits-1:0] DutyPerStep = DutyBits'(10);
   localparam logic [DutyBits-1:0] DutyFull    = DutyBits'(100);

   // Prescaler limits
   localparam logic [PrescaleBits-1:0] MaxDivisor = PrescaleBits'(1024);

   // Compare value is (top * step) / 10; the division is a reciprocal
   // multiply, exact for products below 2**20
   localparam int ProdBits    = CounterBits + StepBits;
   localparam int RecipBits   = 20;
   localparam int RecipShift  = 23;
   localparam int MulBits     = ProdBits + RecipBits;
   localparam logic [RecipBits-1:0] Recip = RecipBits'(838861);

   // Reset values of registers and state
   localparam logic [TopBits-1:0]      ResetTop      = TopBits'(15624);
   localparam logic [PrescaleBits-1:0] ResetPrescale = PrescaleBits'(1024);
   localparam logic [DebounceBits-1:0] ResetDebounce = DebounceBits'(320000);
   localparam logic [StepBits-1:0]     ResetStep     = StepBits'(1);
   localparam logic [CounterBits-1:0]  ResetCompare  =
      CounterBits'((15624 * 1) / 10);

   // Register indexes (byte address / 4)
   localparam logic [1:0] RegTop      = 2'd0;
   localparam logic [1:0] RegPrescale = 2'd1;
   localparam logic [1:0] RegDebounce = 2'd2;

   typedef struct packed {
      logic up_pressed;
      logic down_pressed;
   } req_type;

   typedef struct packed {
      logic                pwm_out;
      logic [DutyBits-1:0] duty_percent;
   } rsp_type;

   typedef struct packed {
      logic [TopBits-1:0]      top_value;
      logic [PrescaleBits-1:0] prescale_divisor;
      logic [DebounceBits-1:0] debounce_ticks;
   } cfg_type;

endpackage

### design/bspwm_button.sv
// ----------------------------------------------------------------------------
// bspwm_button
// Edge detect and debounce timer for one button; flags a confirmed press.
// ----------------------------------------------------------------------------
module bspwm_button (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  advance,
   input  logic                                  level,
   input  logic [bspwm_pkg::DebounceBits-1:0]    debounce_ticks,
   output logic                                  step
);

   logic                               was_ff, was_in;
   logic                               waiting_ff, waiting_in;
   logic [bspwm_pkg::DebounceBits-1:0] wait_ff, wait_in;
   logic                               start;
   logic [bspwm_pkg::DebounceBits-1:0] cur_wait;

   // Start a wait on a fresh press; a zero wait resamples at once
   always_comb begin
      start      = !waiting_ff && !was_ff && level;
      cur_wait   = waiting_ff ? wait_ff : debounce_ticks;
      was_in     = was_ff;
      waiting_in = waiting_ff;
      wait_in    = wait_ff;
      step       = 1'b0;
      if (waiting_ff || start) begin
         if (cur_wait == '0) begin
            waiting_in = 1'b0;
            was_in     = level;
            step       = level;
         end else begin
            waiting_in = 1'b1;
            wait_in    = cur_wait - 1'b1;
         end
      end else begin
         was_in = level;
      end
   end

   // Advance once per processed request
   always_ff @(posedge clock) begin
      if (reset) begin
         was_ff     <= 1'b0;
         waiting_ff <= 1'b0;
         wait_ff    <= '0;
      end else if (advance) begin
         was_ff     <= was_in;
         waiting_ff <= waiting_in;
         wait_ff    <= wait_in;
      end
   end

endmodule

### design/bspwm_timer.sv
// ----------------------------------------------------------------------------
// bspwm_timer
// Prescaler, up-counter with wrap at top, compare reload at bottom.
// ----------------------------------------------------------------------------
module bspwm_timer (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               advance,
   input  bspwm_pkg::cfg_type                 cfg,
   input  logic [bspwm_pkg::StepBits-1:0]     step_next,
   output logic                               pwm_next
);

   logic [bspwm_pkg::PrescaleCntBits-1:0] prescale_ff, prescale_in;
   logic [bspwm_pkg::CounterBits-1:0]     timer_ff, timer_in;
   logic [bspwm_pkg::CounterBits-1:0]     compare_ff, compare_in;
   logic [bspwm_pkg::ProdBits-1:0]        prod_ff [bspwm_pkg::MaxStep+1];

   logic [bspwm_pkg::CounterBits-1:0]     top_eff;
   logic [bspwm_pkg::PrescaleBits-1:0]    div_eff;
   logic                                  tick;
   logic [bspwm_pkg::MulBits-1:0]         scaled;
   logic [bspwm_pkg::CounterBits-1:0]     compare_new;

   assign top_eff = bspwm_pkg::CounterBits'(cfg.top_value);

   // Hold top times each duty step, refreshed every cycle from the register
   always_ff @(posedge clock) begin
      for (int k = 0; k <= bspwm_pkg::MaxStep; k++) begin
         prod_ff[k] <= bspwm_pkg::ProdBits'(top_eff) *
                       bspwm_pkg::ProdBits'(k);
      end
   end

   // Divide the selected product by ten
   always_comb begin
      scaled = bspwm_pkg::MulBits'(prod_ff[step_next]) *
               bspwm_pkg::MulBits'(bspwm_pkg::Recip);
      compare_new = bspwm_pkg::CounterBits'(scaled >> bspwm_pkg::RecipShift);
   end

   // Clamp the divisor to 1..1024
   always_comb begin
      priority if (cfg.prescale_divisor == '0) begin
         div_eff = bspwm_pkg::PrescaleBits'(1);
      end else if (cfg.prescale_divisor > bspwm_pkg::MaxDivisor) begin
         div_eff = bspwm_pkg::MaxDivisor;
      end else begin
         div_eff = cfg.prescale_divisor;
      end
   end

   // Advance prescaler and counter; reload compare at bottom
   always_comb begin
      tick        = ({1'b0, prescale_ff} + 1'b1) >= div_eff;
      prescale_in = prescale_ff + 1'b1;
      timer_in    = timer_ff;
      compare_in  = compare_ff;
      if (tick) begin
         prescale_in = '0;
         if (timer_ff >= top_eff) begin
            timer_in   = '0;
            compare_in = compare_new;
         end else begin
            timer_in = timer_ff + 1'b1;
         end
      end
      pwm_next = timer_in <= compare_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prescale_ff <= '0;
         timer_ff    <= '0;
         compare_ff  <= bspwm_pkg::ResetCompare;
      end else if (advance) begin
         prescale_ff <= prescale_in;
         timer_ff    <= timer_in;
         compare_ff  <= compare_in;
      end
   end

endmodule

### design/button_stepped_fast_pwm_core.sv
// ----------------------------------------------------------------------------
// button_stepped_fast_pwm_core
// Fast PWM timer whose duty is stepped by two debounced buttons.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   req_data (up, down levels)
//   rsp      out        rsp_valid/rsp_stall   rsp_data (pwm level, duty)
//   csr      in         psel/penable/pready   paddr, pwdata, prdata
//
// One request per cycle is accepted while req_stall is low; each result
// passes the input register and the result register around the single update
// of counter, compare and duty state.
// Synchronous reset clears all state but the request, result and product data.
// A stalled result holds the pipeline; req_stall rises only while both the
// input register and the result register are occupied and rsp is stalled.
// ----------------------------------------------------------------------------
`include "button_stepped_fast_pwm_core_macros.svh"

module button_stepped_fast_pwm_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  bspwm_pkg::req_type                req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output bspwm_pkg::rsp_type                rsp_data,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [bspwm_pkg::AddrBits-1:0]    paddr,
   input  logic [bspwm_pkg::DataBits-1:0]    pwdata,
   output logic [bspwm_pkg::DataBits-1:0]    prdata,
   output logic                              pready
);

   bspwm_pkg::cfg_type                cfg_ff;
   logic                              in_valid_ff, in_valid_in;
   bspwm_pkg::req_type                in_data_ff;
   logic                              rsp_valid_ff, rsp_valid_in;
   bspwm_pkg::rsp_type                rsp_data_ff, rsp_data_in;
   logic [bspwm_pkg::StepBits-1:0]    duty_step_ff, duty_step_in;
   logic [bspwm_pkg::StepBits-1:0]    step_after_up;
   logic                              out_free, fire, accept;
   logic                              up_step, down_step, pwm_next;
   logic                              cfg_write;

   // Configuration registers
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.top_value        <= bspwm_pkg::ResetTop;
         cfg_ff.prescale_divisor <= bspwm_pkg::ResetPrescale;
         cfg_ff.debounce_ticks   <= bspwm_pkg::ResetDebounce;
      end else if (cfg_write) begin
         unique case (paddr[3:2])
            bspwm_pkg::RegTop:
               cfg_ff.top_value <= pwdata[bspwm_pkg::TopBits-1:0];
            bspwm_pkg::RegPrescale:
               cfg_ff.prescale_divisor <= pwdata[bspwm_pkg::PrescaleBits-1:0];
            bspwm_pkg::RegDebounce:
               cfg_ff.debounce_ticks <= pwdata[bspwm_pkg::DebounceBits-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         bspwm_pkg::RegTop:
            prdata = bspwm_pkg::DataBits'(cfg_ff.top_value);
         bspwm_pkg::RegPrescale:
            prdata = bspwm_pkg::DataBits'(cfg_ff.prescale_divisor);
         bspwm_pkg::RegDebounce:
            prdata = bspwm_pkg::DataBits'(cfg_ff.debounce_ticks);
         default:
            prdata = '0;
      endcase
   end

   // Handshake: process a request when the result slot is free or draining
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture the request and the result
   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_data;
      end
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   bspwm_button u_up_button (
      .clock          (clock),
      .reset          (reset),
      .advance        (fire),
      .level          (in_data_ff.up_pressed),
      .debounce_ticks (cfg_ff.debounce_ticks),
      .step           (up_step)
   );

   bspwm_button u_down_button (
      .clock          (clock),
      .reset          (reset),
      .advance        (fire),
      .level          (in_data_ff.down_pressed),
      .debounce_ticks (cfg_ff.debounce_ticks),
      .step           (down_step)
   );

   // Step duty: up first, then down, within 0..100 percent
   always_comb begin
      step_after_up = duty_step_ff;
      if (up_step && (duty_step_ff <= bspwm_pkg::StepLimit)) begin
         step_after_up = duty_step_ff + 1'b1;
      end
      duty_step_in = step_after_up;
      if (down_step && (step_after_up != '0)) begin
         duty_step_in = step_after_up - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         duty_step_ff <= bspwm_pkg::ResetStep;
      end else if (fire) begin
         duty_step_ff <= duty_step_in;
      end
   end

   bspwm_timer u_timer (
      .clock     (clock),
      .reset     (reset),
      .advance   (fire),
      .cfg       (cfg_ff),
      .step_next (duty_step_in),
      .pwm_next  (pwm_next)
   );

   always_comb begin
      rsp_data_in.pwm_out      = pwm_next;
      rsp_data_in.duty_percent = bspwm_pkg::DutyBits'(duty_step_in) *
                                 bspwm_pkg::DutyPerStep;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Checks
   `BSPWM_ASSERT_NEXT(a_accept_fills_input, clock, reset, accept, in_valid_ff,
      "accepted request lost")
   `BSPWM_ASSERT_NEXT(a_fire_gives_result, clock, reset, fire, rsp_valid_ff,
      "processed request gave no result")
   `BSPWM_ASSERT_NEXT(a_duty_holds_idle, clock, reset, !fire,
      duty_step_ff == $past(duty_step_ff), "duty changed without a request")
   `BSPWM_ASSERT_NOW(a_duty_in_range, clock, reset, rsp_valid_ff,
      rsp_data_ff.duty_percent <= bspwm_pkg::DutyFull, "duty above full scale")

endmodule
